FILE: rtl/core/bawc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bawc_pkg;

  // Set limits and field widths
  localparam int unsigned MAX_BOXES  = 256;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CEN_W      = COORD_BITS + 1;              // centre / centroid
  localparam int unsigned CNT_W      = $clog2(MAX_BOXES + 1);       // boxes in a set
  localparam int unsigned SET_W      = $clog2(MAX_BOXES);           // growth of a set sum
  localparam int unsigned MASS_W     = 2 * COORD_BITS;
  localparam int unsigned PROD_W     = MASS_W + CEN_W;
  localparam int unsigned ACC_W      = PROD_W + SET_W;
  localparam int unsigned MSUM_W     = MASS_W + SET_W;

  // Divider: one quotient bit per step
  localparam int unsigned QUO_W  = CEN_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  // Set queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
    logic                  last_box;
  } box_t;

  typedef struct packed {
    logic [CEN_W-1:0] centroid_x;
    logic [CEN_W-1:0] centroid_y;
    logic             zero_mass;
    logic             too_many_boxes;
  } res_t;

  // Finished set totals handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0]  wx_sum;
    logic [ACC_W-1:0]  wy_sum;
    logic [MSUM_W-1:0] mass_sum;
    logic              ovf;
  } set_tot_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/bawc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bawc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire bawc_pkg::box_t     box_i,
  input  wire bawc_pkg::q_stat_t  q_stat_i,
  output logic                    q_push_o,
  output bawc_pkg::set_tot_t      q_data_o
);
  import bawc_pkg::*;

  logic               accept;
  logic               keep;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // stage 1: mass and centre
  logic               s1_vld_q, s1_last_q, s1_ovf_q;
  logic [MASS_W-1:0]  s1_mass_q;
  logic [CEN_W-1:0]   s1_cx_q, s1_cy_q;

  // stage 2: weighted centre
  logic               s2_vld_q, s2_last_q, s2_ovf_q;
  logic [MASS_W-1:0]  s2_mass_q;
  logic [PROD_W-1:0]  s2_px_q, s2_py_q;

  // accumulators
  logic [ACC_W-1:0]   wx_q, wx_d, wy_q, wy_d;
  logic [MSUM_W-1:0]  m_q, m_d;
  logic               ovf_q, ovf_d;

  logic [QCNT_W:0]    need;

  // reserve a queue slot for every set end still in the pipe
  assign need   = {1'b0, q_stat_i.count}
                + (QCNT_W+1)'(s1_vld_q & s1_last_q)
                + (QCNT_W+1)'(s2_vld_q & s2_last_q);
  assign full_o = (need >= (QCNT_W+1)'(QDEPTH));
  assign accept = push_i & ~full_o;
  assign keep   = (cnt_q < CNT_W'(MAX_BOXES));

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (box_i.last_box) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      wx_q     <= '0;
      wy_q     <= '0;
      m_q      <= '0;
      ovf_q    <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      wx_q     <= wx_d;
      wy_q     <= wy_d;
      m_q      <= m_d;
      ovf_q    <= ovf_d;
    end
  end

  // a dropped box carries zero mass
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= box_i.last_box;
      s1_ovf_q  <= ~keep;
      s1_mass_q <= keep ? (MASS_W'(box_i.box_w) * MASS_W'(box_i.box_h)) : '0;
      s1_cx_q   <= {1'b0, box_i.box_x} + CEN_W'(box_i.box_w >> 1);
      s1_cy_q   <= {1'b0, box_i.box_y} + CEN_W'(box_i.box_h >> 1);
    end
    s2_last_q <= s1_last_q;
    s2_ovf_q  <= s1_ovf_q;
    s2_mass_q <= s1_mass_q;
    s2_px_q   <= PROD_W'(s1_mass_q) * PROD_W'(s1_cx_q);
    s2_py_q   <= PROD_W'(s1_mass_q) * PROD_W'(s1_cy_q);
  end

  always_comb begin
    q_data_o.wx_sum   = wx_q + ACC_W'(s2_px_q);
    q_data_o.wy_sum   = wy_q + ACC_W'(s2_py_q);
    q_data_o.mass_sum = m_q + MSUM_W'(s2_mass_q);
    q_data_o.ovf      = ovf_q | s2_ovf_q;
    q_push_o          = s2_vld_q & s2_last_q;

    wx_d  = wx_q;
    wy_d  = wy_q;
    m_d   = m_q;
    ovf_d = ovf_q;
    if (s2_vld_q) begin
      if (s2_last_q) begin
        wx_d  = '0;
        wy_d  = '0;
        m_d   = '0;
        ovf_d = 1'b0;
      end else begin
        wx_d  = q_data_o.wx_sum;
        wy_d  = q_data_o.wy_sum;
        m_d   = q_data_o.mass_sum;
        ovf_d = q_data_o.ovf;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bawc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bawc_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire bawc_pkg::set_tot_t  data_i,
  input  wire logic                pop_i,
  output bawc_pkg::set_tot_t       data_o,
  output bawc_pkg::q_stat_t        stat_o
);
  import bawc_pkg::*;

  set_tot_t           mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_pop;

  assign do_pop       = pop_i & (cnt_q != '0);
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign data_o       = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bawc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bawc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bawc_pkg::q_stat_t   q_stat_i,
  input  wire bawc_pkg::set_tot_t  q_data_i,
  output logic                     q_pop_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output bawc_pkg::res_t           res_o
);
  import bawc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [STEP_W-1:0]  step_q;
  logic [ACC_W-1:0]   remx_q, remy_q, dsh_q;
  logic [QUO_W-1:0]   qx_q, qy_q;
  logic               zero_q, ovf_q;
  logic               out_vld_q;
  res_t               out_q;
  logic               gex, gey, load, emit;

  assign gex = (remx_q >= dsh_q);
  assign gey = (remy_q >= dsh_q);

  assign load    = (st_q == ST_IDLE) & ~q_stat_i.empty;
  assign emit    = (st_q == ST_DONE) & (~out_vld_q | pop_i);
  assign q_pop_o = load;
  assign empty_o = ~out_vld_q;
  assign res_o   = out_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (load) st_d = ST_DIV;
      ST_DIV:  if (step_q == '0) st_d = ST_DONE;
      ST_DONE: if (emit) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) begin
        step_q <= STEP_W'(QUO_W - 1);
      end else if (st_q == ST_DIV) begin
        step_q <= step_q - STEP_W'(1);
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // restoring division, divisor walks down from its top alignment
  always_ff @(posedge clk_i) begin
    if (load) begin
      remx_q <= q_data_i.wx_sum;
      remy_q <= q_data_i.wy_sum;
      dsh_q  <= ACC_W'(q_data_i.mass_sum) << (QUO_W - 1);
      zero_q <= (q_data_i.mass_sum == '0);
      ovf_q  <= q_data_i.ovf;
    end else if (st_q == ST_DIV) begin
      remx_q <= gex ? (remx_q - dsh_q) : remx_q;
      remy_q <= gey ? (remy_q - dsh_q) : remy_q;
      qx_q   <= {qx_q[QUO_W-2:0], gex};
      qy_q   <= {qy_q[QUO_W-2:0], gey};
      dsh_q  <= dsh_q >> 1;
    end
    if (emit) begin
      out_q.centroid_x     <= zero_q ? '0 : qx_q;
      out_q.centroid_y     <= zero_q ? '0 : qy_q;
      out_q.zero_mass      <= zero_q;
      out_q.too_many_boxes <= ovf_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/box_area_weighted_centroid.sv
// Channel  | Handshake     | Payload | Beat
// ---------+---------------+---------+--------------------------------------
// box in   | push / full   | box_i   | one box (x, y, w, h, last_box)
// result   | empty / pop   | res_o   | one centroid per set, on its last box
//
// Boxes are taken one per cycle while full is low; an accepted box passes the mass
// and centre, weighted centre and sum registers. A set end is queued (2 entries)
// to a shared restoring divider that yields one quotient bit of x and y per cycle:
// each set takes a pop, 13 steps and a write. full rises when queue plus set ends
// in flight fill the queue; a held result stalls the divider, and full follows once
// the queue fills. Reset is async, active low; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module box_area_weighted_centroid (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire bawc_pkg::box_t  box_i,
  output logic                 empty,
  input  wire logic            pop,
  output bawc_pkg::res_t       res_o
);
  import bawc_pkg::*;

  // front -> queue
  logic      q_push;
  set_tot_t  q_wdata;
  // queue -> back
  set_tot_t  q_rdata;
  q_stat_t   q_stat;
  logic      q_pop;

  // Accepts boxes, drops those past MAX_BOXES, keeps per-set sums.
  bawc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .box_i    (box_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Finished set totals wait here while the divider is busy.
  bawc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // Divides the sums and holds the result beat in its output register.
  bawc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .res_o    (res_o)
  );

`ifndef ASSERT_OFF
  // slot reservation in the front must keep the queue from overrunning
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_stat.count < QCNT_W'(QDEPTH)))
    else $error("set queue overrun");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("set queue underrun");

  a_zero_mass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.zero_mass) |-> (res_o.centroid_x == '0 && res_o.centroid_y == '0))
    else $error("zero mass result with nonzero centroid");

  // weighted mean cannot exceed the largest possible box centre
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.centroid_x <= CEN_W'(2 * ((1 << COORD_BITS) - 1) / 2 +
                                           ((1 << COORD_BITS) - 1) / 2)))
    else $error("centroid out of range");
`endif

endmodule

`default_nettype wire
